>>> src/jss_pkg.sv
// jss_pkg: shared types and constants for the jacobi stencil sweep block
// no dependencies; imported by jss_relax and jacobi_stencil_sweep
package jss_pkg;

   // register widths fixed by the register map
   localparam int GRID_WIDTH_BITS  = 11;
   localparam int GRID_HEIGHT_BITS = 16;
   localparam int THRESHOLD_BITS   = 24;
   localparam int CSR_DATA_BITS    = 24;
   localparam int CSR_INDEX_BITS   = 2;

   // result field widths
   localparam int ROW_BITS    = 16;
   localparam int COLUMN_BITS = 10;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_WIDTH         = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GRID_HEIGHT        = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONVERGE_THRESHOLD = 2'd2;

   // register reset values (threshold is 0.001 in Q3.21)
   localparam logic [GRID_WIDTH_BITS-1:0]  GRID_WIDTH_RESET  = 11'd64;
   localparam logic [GRID_HEIGHT_BITS-1:0] GRID_HEIGHT_RESET = 16'd64;
   localparam logic [THRESHOLD_BITS-1:0]   THRESHOLD_RESET   = 24'd2097;

   // smallest usable grid side
   localparam int MIN_GRID = 3;

   // per-cell decisions made when the word is taken in
   typedef struct packed {
      logic emit_above;   // row above is released by this cell
      logic emit_self;    // cell sits on the last row and goes out as well
      logic interior;     // the released cell is relaxed
      logic done;         // last cell of the grid
      logic clear_max;    // first cell of the grid
   } step_ctl_type;

endpackage

>>> src/jacobi_stencil_sweep.sv
// jacobi_stencil_sweep: streaming five-point jacobi relaxation sweep, top level
// depends on jss_pkg, jss_line_buf, jss_relax and jss_rsp_queue
//
//   channel   direction  handshake                  payload
//   req_      in         req_valid / req_stall      req_cell_in
//   rsp_      out        rsp_valid / rsp_stall      rsp_cell_out, rsp_column, rsp_row,
//                                                   rsp_max_change, rsp_converged,
//                                                   rsp_sweep_done
//   csr_      in         csr_write_en               csr_index, csr_write_data
//
// one cell word is taken per cycle while req_stall is low; a taken cell is held in the
// compute stage, and its words reach the result queue when that stage advances
// cells of the last row give two words, so there req_stall holds off the next cell
// while the result port drains them; the other rows after the first give one word each
// a two-entry result queue lets a new cell in while a result word waits on rsp_stall
// synchronous reset clears counters, running maximum, queue and registers to defaults
module jacobi_stencil_sweep
   import jss_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int VALUE_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   // cell input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_BITS-1:0]  req_cell_in,
   // result output
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [VALUE_BITS-1:0]  rsp_cell_out,
   output logic [COLUMN_BITS-1:0]        rsp_column,
   output logic [ROW_BITS-1:0]           rsp_row,
   output logic [VALUE_BITS-1:0]         rsp_max_change,
   output logic                          rsp_converged,
   output logic                          rsp_sweep_done,
   // register writes
   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_write_data
);

   localparam int COL_BITS   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMP_BITS   = (VALUE_BITS > THRESHOLD_BITS) ? VALUE_BITS : THRESHOLD_BITS;
   localparam int ENTRY_BITS = VALUE_BITS + COL_BITS + ROW_BITS + VALUE_BITS + 2;

   // registers
   logic [GRID_WIDTH_BITS-1:0]  grid_width_ff;
   logic [GRID_HEIGHT_BITS-1:0] grid_height_ff;
   logic [THRESHOLD_BITS-1:0]   threshold_ff;

   // raster position
   logic [COL_BITS-1:0] col_cnt_ff, col_cnt_in;
   logic [ROW_BITS-1:0] row_cnt_ff, row_cnt_in;

   // compute stage
   logic                         s0_valid_ff, s0_valid_in;
   logic signed [VALUE_BITS-1:0] s0_cell_ff;
   logic [COL_BITS-1:0]          s0_col_ff;
   logic [ROW_BITS-1:0]          s0_row_ff;
   step_ctl_type                 s0_ctl_ff, s0_ctl_in;

   logic [COL_BITS-1:0]          width_last;
   logic [ROW_BITS-1:0]          height_last;
   logic [31:0]                  width_wide;
   logic                         accept;
   logic                         advance;
   logic [1:0]                   need;
   logic [1:0]                   free_slots;
   logic signed [VALUE_BITS-1:0] centre, left, right, up, relaxed;
   logic [VALUE_BITS-1:0]        max_change;
   logic                         converged;
   logic [ENTRY_BITS-1:0]        entry_a, entry_b, head;
   logic [COL_BITS-1:0]          head_col;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RESET;
         grid_height_ff <= GRID_HEIGHT_RESET;
         threshold_ff   <= THRESHOLD_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:         grid_width_ff  <= csr_write_data[GRID_WIDTH_BITS-1:0];
            CSR_GRID_HEIGHT:        grid_height_ff <= csr_write_data[GRID_HEIGHT_BITS-1:0];
            CSR_CONVERGE_THRESHOLD: threshold_ff   <= csr_write_data[THRESHOLD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // last column and last row of the clamped grid
   always_comb begin
      width_wide = 32'(grid_width_ff);
      if (width_wide < 32'(MIN_GRID)) begin
         width_last = COL_BITS'(MIN_GRID - 1);
      end else if (width_wide > 32'(MAX_WIDTH)) begin
         width_last = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         width_last = COL_BITS'(width_wide - 32'd1);
      end
      if (grid_height_ff < GRID_HEIGHT_BITS'(MIN_GRID)) begin
         height_last = ROW_BITS'(MIN_GRID - 1);
      end else begin
         height_last = ROW_BITS'(grid_height_ff - 1'b1);
      end
   end

   // handshake: the stage moves on when the queue has room for its words
   assign need      = {1'b0, s0_ctl_ff.emit_above} + {1'b0, s0_ctl_ff.emit_self};
   assign advance   = s0_valid_ff && (need <= free_slots);
   assign req_stall = s0_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // classify the incoming cell and step the raster counters
   always_comb begin
      s0_ctl_in.emit_above = (row_cnt_ff != '0);
      s0_ctl_in.emit_self  = (row_cnt_ff >= height_last);
      s0_ctl_in.interior   = (row_cnt_ff >= ROW_BITS'(2)) && (row_cnt_ff <= height_last)
                           && (col_cnt_ff != '0) && (col_cnt_ff < width_last);
      s0_ctl_in.done       = (row_cnt_ff >= height_last) && (col_cnt_ff >= width_last);
      s0_ctl_in.clear_max  = (row_cnt_ff == '0) && (col_cnt_ff == '0);
      if (col_cnt_ff >= width_last) begin
         col_cnt_in = '0;
         row_cnt_in = (row_cnt_ff >= height_last) ? '0 : ROW_BITS'(row_cnt_ff + 1'b1);
      end else begin
         col_cnt_in = COL_BITS'(col_cnt_ff + 1'b1);
         row_cnt_in = row_cnt_ff;
      end
      s0_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s0_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         if (accept) begin
            col_cnt_ff <= col_cnt_in;
            row_cnt_ff <= row_cnt_in;
         end
      end
   end

   // compute stage payload
   always_ff @(posedge clock) begin
      if (accept) begin
         s0_cell_ff <= req_cell_in;
         s0_col_ff  <= col_cnt_ff;
         s0_row_ff  <= row_cnt_ff;
         s0_ctl_ff  <= s0_ctl_in;
      end
   end

   jss_line_buf #(
      .MAX_WIDTH  (MAX_WIDTH),
      .VALUE_BITS (VALUE_BITS),
      .COL_BITS   (COL_BITS)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_col  (col_cnt_ff),
      .wr_en   (advance),
      .wr_col  (s0_col_ff),
      .wr_data (s0_cell_ff),
      .centre  (centre),
      .right   (right),
      .up      (up),
      .left    (left)
   );

   jss_relax #(
      .VALUE_BITS (VALUE_BITS)
   ) u_relax (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .ctl        (s0_ctl_ff),
      .cell_value (s0_cell_ff),
      .centre     (centre),
      .left       (left),
      .right      (right),
      .up         (up),
      .relaxed    (relaxed),
      .max_change (max_change)
   );

   // result words: the cell above, then the arriving cell on the last row
   assign converged = s0_ctl_ff.done
                    && (CMP_BITS'(max_change) < CMP_BITS'(threshold_ff));
   assign entry_a   = {relaxed, s0_col_ff, ROW_BITS'(s0_row_ff - 1'b1), max_change,
                       1'b0, 1'b0};
   assign entry_b   = {s0_cell_ff, s0_col_ff, s0_row_ff, max_change,
                       converged, s0_ctl_ff.done};

   jss_rsp_queue #(
      .ENTRY_BITS (ENTRY_BITS)
   ) u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_a     (advance && s0_ctl_ff.emit_above),
      .entry_a    (entry_a),
      .push_b     (advance && s0_ctl_ff.emit_self),
      .entry_b    (entry_b),
      .out_stall  (rsp_stall),
      .out_valid  (rsp_valid),
      .out_entry  (head),
      .free_slots (free_slots)
   );

   // unpack the head word
   assign {rsp_cell_out, head_col, rsp_row, rsp_max_change, rsp_converged,
           rsp_sweep_done} = head;
   assign rsp_column = COLUMN_BITS'(head_col);

`ifndef SYNTHESIS
   // a full stage takes a new cell only while it hands on its own
   a_stage_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (accept && s0_valid_ff) |-> advance)
      else $error("compute stage overwritten");

   // the last cell of the grid sends the counters back to the origin
   a_grid_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && s0_ctl_in.done) |=> (col_cnt_ff == '0 && row_cnt_ff == '0))
      else $error("raster counters did not wrap after last cell");

   // converged only rides on the final word of the grid
   a_converged_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_converged) |-> rsp_sweep_done)
      else $error("converged flag outside final word");
`endif

endmodule

>>> src/jss_line_buf.sv
// jss_line_buf: two row line buffers with the stencil window around the cell
// no package dependencies; used by jacobi_stencil_sweep
module jss_line_buf #(
   parameter int MAX_WIDTH  = 1024,
   parameter int VALUE_BITS = 24,
   parameter int COL_BITS   = 10
) (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [COL_BITS-1:0]          rd_col,
   input  logic                         wr_en,
   input  logic [COL_BITS-1:0]          wr_col,
   input  logic signed [VALUE_BITS-1:0] wr_data,
   output logic signed [VALUE_BITS-1:0] centre,
   output logic signed [VALUE_BITS-1:0] right,
   output logic signed [VALUE_BITS-1:0] up,
   output logic signed [VALUE_BITS-1:0] left
);

   logic signed [VALUE_BITS-1:0] above_mem [MAX_WIDTH];
   logic signed [VALUE_BITS-1:0] two_above_mem [MAX_WIDTH];

   logic signed [VALUE_BITS-1:0] centre_ff;
   logic signed [VALUE_BITS-1:0] right_ff;
   logic signed [VALUE_BITS-1:0] up_ff;
   logic signed [VALUE_BITS-1:0] left_ff;
   logic [COL_BITS-1:0]          rd_next_col;

   assign rd_next_col = COL_BITS'(rd_col + 1'b1);

   // window read when a word is taken in
   always_ff @(posedge clock) begin
      if (rd_en) begin
         centre_ff <= above_mem[rd_col];
         right_ff  <= above_mem[rd_next_col];
         up_ff     <= two_above_mem[rd_col];
      end
   end

   // shift the rows down as the cell leaves; old centre becomes left of next cell
   always_ff @(posedge clock) begin
      if (wr_en) begin
         above_mem[wr_col]     <= wr_data;
         two_above_mem[wr_col] <= centre_ff;
         left_ff               <= centre_ff;
      end
   end

   assign centre = centre_ff;
   assign right  = right_ff;
   assign up     = up_ff;
   assign left   = left_ff;

endmodule

>>> src/jss_relax.sv
// jss_relax: five-point relaxation of one cell and the running maximum change
// depends on jss_pkg (step_ctl_type); used by jacobi_stencil_sweep
module jss_relax
   import jss_pkg::*;
#(
   parameter int VALUE_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  step_ctl_type                 ctl,
   input  logic signed [VALUE_BITS-1:0] cell_value,
   input  logic signed [VALUE_BITS-1:0] centre,
   input  logic signed [VALUE_BITS-1:0] left,
   input  logic signed [VALUE_BITS-1:0] right,
   input  logic signed [VALUE_BITS-1:0] up,
   output logic signed [VALUE_BITS-1:0] relaxed,
   output logic [VALUE_BITS-1:0]        max_change
);

   logic [VALUE_BITS-1:0]        max_ff;
   logic [VALUE_BITS-1:0]        max_in;
   logic signed [VALUE_BITS+1:0] sum;
   logic signed [VALUE_BITS+1:0] quarter;
   logic signed [VALUE_BITS-1:0] new_value;
   logic signed [VALUE_BITS:0]   diff;
   logic [VALUE_BITS:0]          abs_diff;
   logic [VALUE_BITS-1:0]        change;
   logic [VALUE_BITS-1:0]        max_base;

   // floor of the neighbour sum over four
   always_comb begin
      sum = (VALUE_BITS+2)'(left) + (VALUE_BITS+2)'(right)
          + (VALUE_BITS+2)'(up) + (VALUE_BITS+2)'(cell_value);
      quarter   = sum >>> 2;
      new_value = quarter[VALUE_BITS-1:0];
      relaxed   = ctl.interior ? new_value : centre;
   end

   // absolute change against the old value and the running maximum
   always_comb begin
      diff     = (VALUE_BITS+1)'(new_value) - (VALUE_BITS+1)'(centre);
      abs_diff = diff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff) : (VALUE_BITS+1)'(diff);
      change   = abs_diff[VALUE_BITS-1:0];
      max_base = ctl.clear_max ? '0 : max_ff;
      max_in   = (ctl.interior && (change > max_base)) ? change : max_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= '0;
      end else if (advance) begin
         max_ff <= max_in;
      end
   end

   assign max_change = max_in;

endmodule

>>> src/jss_rsp_queue.sv
// jss_rsp_queue: two-entry result queue in front of the result channel
// no package dependencies; used by jacobi_stencil_sweep
module jss_rsp_queue #(
   parameter int ENTRY_BITS = 100
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_a,
   input  logic [ENTRY_BITS-1:0] entry_a,
   input  logic                  push_b,
   input  logic [ENTRY_BITS-1:0] entry_b,
   input  logic                  out_stall,
   output logic                  out_valid,
   output logic [ENTRY_BITS-1:0] out_entry,
   output logic [1:0]            free_slots
);

   localparam logic [1:0] SLOTS = 2'd2;

   logic [ENTRY_BITS-1:0] head_ff, head_in;
   logic [ENTRY_BITS-1:0] tail_ff, tail_in;
   logic [1:0]            count_ff, count_in;
   logic                  pop;
   logic [1:0]            level;

   assign out_valid  = (count_ff != 2'd0);
   assign out_entry  = head_ff;
   assign pop        = out_valid && !out_stall;
   assign free_slots = 2'(SLOTS - count_ff + {1'b0, pop});

   // pop first, then append the first and second word of the cell
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      level   = count_ff;
      if (pop) begin
         head_in = tail_ff;
         level   = 2'(level - 2'd1);
      end
      if (push_a) begin
         if (level == 2'd0) begin
            head_in = entry_a;
         end else begin
            tail_in = entry_a;
         end
         level = 2'(level + 2'd1);
      end
      if (push_b) begin
         if (level == 2'd0) begin
            head_in = entry_b;
         end else begin
            tail_in = entry_b;
         end
         level = 2'(level + 2'd1);
      end
      count_in = level;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

`ifndef SYNTHESIS
   // never more words than slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue over capacity");

   // a push never overruns the space that was offered
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      (push_a || push_b) |-> ({1'b0, push_a} + {1'b0, push_b} <= free_slots))
      else $error("result queue push beyond free space");
`endif

endmodule
